FILE: rtl/core/prt_pkg.sv
`default_nettype none

package prt_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_DIV  = 2'd0,
        REG_CNT  = 2'd1,
        REG_MOD  = 2'd2,
        REG_CTRL = 2'd3
    } reg_sel_t;

    localparam int unsigned TICK_W       = 10;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned CTRL_EN_BIT  = 2;
    localparam logic [7:0]  DIV_TAP      = 8'hFF;
    localparam logic [7:0]  CNT_TOP      = 8'hFF;

    typedef struct packed {
        op_t                op;
        reg_sel_t           reg_sel;
        logic [DATA_W-1:0]  wdata;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  rdata;
        logic               timer_irq;
    } result_t;

    // tick-count mask for periods 1024, 16, 64, 256
    function automatic logic [TICK_W-1:0] period_mask(input logic [1:0] sel);
        logic [TICK_W-1:0] m;
        case (sel)
            2'd0:    m = 10'h3FF;
            2'd1:    m = 10'h00F;
            2'd2:    m = 10'h03F;
            2'd3:    m = 10'h0FF;
            default: m = 10'h3FF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/prt_core.sv
`default_nettype none

module prt_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire prt_pkg::item_t  item,
    output prt_pkg::result_t     result
);

    logic [prt_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [prt_pkg::DATA_W-1:0] div_reg, div_next;
    logic [prt_pkg::DATA_W-1:0] cnt_reg, cnt_next;
    logic [prt_pkg::DATA_W-1:0] mod_reg, mod_next;
    logic [prt_pkg::DATA_W-1:0] ctrl_reg, ctrl_next;

    logic [prt_pkg::TICK_W-1:0] tick_inc;
    logic [prt_pkg::TICK_W-1:0] mask;
    logic                       cnt_hit;

    assign tick_inc = tick_reg + 10'd1;
    assign mask     = prt_pkg::period_mask(ctrl_reg[1:0]);
    assign cnt_hit  = ctrl_reg[prt_pkg::CTRL_EN_BIT] && ((tick_inc & mask) == mask);

    always_comb begin
        tick_next        = tick_reg;
        div_next         = div_reg;
        cnt_next         = cnt_reg;
        mod_next         = mod_reg;
        ctrl_next        = ctrl_reg;
        result.rdata     = '0;
        result.timer_irq = 1'b0;
        case (item.op)
            prt_pkg::OP_TICK: begin
                tick_next = tick_inc;
                if (tick_inc[7:0] == prt_pkg::DIV_TAP) begin
                    div_next = div_reg + 8'd1;
                end
                if (cnt_hit) begin
                    if (cnt_reg == prt_pkg::CNT_TOP) begin
                        cnt_next         = mod_reg;
                        result.timer_irq = 1'b1;
                    end else begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
            end
            prt_pkg::OP_READ: begin
                case (item.reg_sel)
                    prt_pkg::REG_DIV:  result.rdata = div_reg;
                    prt_pkg::REG_CNT:  result.rdata = cnt_reg;
                    prt_pkg::REG_MOD:  result.rdata = mod_reg;
                    prt_pkg::REG_CTRL: result.rdata = ctrl_reg;
                    default:           result.rdata = '0;
                endcase
            end
            prt_pkg::OP_WRITE: begin
                case (item.reg_sel)
                    prt_pkg::REG_DIV:  div_next  = item.wdata;
                    prt_pkg::REG_CNT:  cnt_next  = item.wdata;
                    prt_pkg::REG_MOD:  mod_next  = item.wdata;
                    prt_pkg::REG_CTRL: ctrl_next = item.wdata;
                    default:           ctrl_next = ctrl_reg;
                endcase
            end
            default: begin
                tick_next = tick_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            mod_reg  <= '0;
            ctrl_reg <= '0;
        end else if (step) begin
            tick_reg <= tick_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            mod_reg  <= mod_next;
            ctrl_reg <= ctrl_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/prescaled_reload_timer.sv
`default_nettype none

// Timer with divider, counter, modulo and control registers. Each input beat
// is a tick, a register read or a register write; each produces exactly one
// output beat (read byte or zero, plus an overflow pulse). One beat is taken
// every cycle while the output side accepts: a beat is captured in an input
// register, processed against the timer state in a single combinational pass,
// and held in a result register before it is offered on the output.
module prescaled_reload_timer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [1:0] reg_sel, [9:2] wdata, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] rdata, [8] timer_irq, rest zero
);

    prt_pkg::item_t   in_reg, in_next;
    logic             in_vld_reg, in_vld_next;
    prt_pkg::result_t res_reg;
    prt_pkg::result_t res_next;
    logic             out_vld_reg, out_vld_next;
    logic             advance;
    logic             s_take;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_next         = in_reg;
        in_vld_next     = in_vld_reg && !advance;
        out_vld_next    = out_vld_reg && !m_tready;
        if (s_take) begin
            in_next.op      = prt_pkg::op_t'(s_tuser);
            in_next.reg_sel = prt_pkg::reg_sel_t'(s_tdata[1:0]);
            in_next.wdata   = s_tdata[9:2];
            in_vld_next     = 1'b1;
        end
        if (advance) begin
            out_vld_next = 1'b1;
        end
    end

    prt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_reg),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg <= in_next;
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, res_reg.timer_irq, res_reg.rdata};

`ifndef SYNTHESIS
    // overflow pulse only comes from a tick beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.op != prt_pkg::OP_TICK |=> !res_reg.timer_irq)
        else $error("timer_irq raised by a non-tick beat");

    // read data only comes from a read beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.op != prt_pkg::OP_READ |=> res_reg.rdata == '0)
        else $error("nonzero rdata on a non-read beat");

    // a captured beat waiting on the output stage must hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_reg))
        else $error("stalled input beat lost or changed");
`endif

endmodule

`default_nettype wire
